// File: hw/rtl/smm_pkg.sv
// smm_pkg: shared types and constants of the square matrix multiply block
// used by the front, queue and back modules; depends on nothing

package smm_pkg;

	// input item kinds
	localparam logic [1:0] KIND_LOAD_A  = 2'd0;
	localparam logic [1:0] KIND_LOAD_B  = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	// field widths fixed by the item format
	localparam int unsigned SIZE_W  = 4;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned ELEM_W  = 16;
	localparam int unsigned PROD_W  = 32;
	localparam int unsigned SUM_W   = 40;

	// element address wide enough for the largest matrix (8 x 8)
	localparam int unsigned ADDR_W = 6;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	// operations that the back carries out
	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	// one queued operation
	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  addr;
		logic [ELEM_W-1:0]  value;
	} qent_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: hw/rtl/smm_in_if.sv
// smm_in_if: input item channel of the square matrix multiply block
// valid/ready handshake with the load and compute fields; depends on nothing

interface smm_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [2:0]        row_index;
	logic [2:0]        col_index;
	logic signed [15:0] element_value;

	modport source (output valid, kind, row_index, col_index, element_value, input ready);
	modport sink (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

// File: hw/rtl/smm_out_if.sv
// smm_out_if: result channel of the square matrix multiply block
// valid/ready handshake with one product element per transfer; depends on nothing

interface smm_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [39:0] product_value;
	logic               last_of_run;

	modport source (output valid, out_row, out_col, product_value, last_of_run, input ready);
	modport sink (input valid, out_row, out_col, product_value, last_of_run, output ready);
endinterface

// File: hw/rtl/smm_ram.sv
// smm_ram: generic single write port, single read port ram with registered read
// used for both matrix stores; depends on nothing

module smm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/smm_front.sv
// smm_front: accepts input items, drops ignored ones and turns the rest into queue entries
// depends on smm_pkg and smm_in_if

module smm_front #(
	parameter int unsigned MAX_DIM = 8
) (
	smm_in_if.sink                        items,
	input  logic [smm_pkg::SIZE_W-1:0]    n_eff,
	input  smm_pkg::qstat_t               qstat,
	output logic                          push,
	output smm_pkg::qent_t                entry
);

	logic in_range;
	logic keep;
	smm_pkg::op_t op;

	// take items whenever the queue has room
	assign items.ready = !qstat.full;

	// load coordinates must lie inside the active matrix
	assign in_range = ({1'b0, items.row_index} < n_eff) && ({1'b0, items.col_index} < n_eff);

	// classify the item
	always_comb begin
		keep = 1'b0;
		op   = smm_pkg::OP_COMPUTE;
		case (items.kind)
			smm_pkg::KIND_LOAD_A: begin
				keep = in_range;
				op   = smm_pkg::OP_LOAD_A;
			end
			smm_pkg::KIND_LOAD_B: begin
				keep = in_range;
				op   = smm_pkg::OP_LOAD_B;
			end
			smm_pkg::KIND_COMPUTE: begin
				keep = (n_eff != '0);
				op   = smm_pkg::OP_COMPUTE;
			end
			default: begin
				keep = 1'b0;
				op   = smm_pkg::OP_COMPUTE;
			end
		endcase
	end

	assign entry.op = op;

	// row-major element address
	assign entry.addr  = smm_pkg::ADDR_W'(32'(items.row_index) * MAX_DIM + 32'(items.col_index));
	assign entry.value = items.element_value;

	assign push = items.valid && items.ready && keep;

endmodule

// File: hw/rtl/smm_queue.sv
// smm_queue: short first-in first-out queue of operations between front and back
// depends on smm_pkg

module smm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smm_pkg::qent_t  push_entry,
	input  logic            pop,
	output smm_pkg::qent_t  head,
	output smm_pkg::qstat_t qstat
);

	smm_pkg::qent_t                    slot_q [smm_pkg::QUEUE_DEPTH];
	logic [smm_pkg::QPTR_W-1:0]        wptr_q;
	logic [smm_pkg::QPTR_W-1:0]        rptr_q;
	logic [smm_pkg::QPTR_W:0]          count_q;

	assign qstat.full  = (count_q == (smm_pkg::QPTR_W + 1)'(smm_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/smm_back.sv
// smm_back: carries out queued loads and runs the multiply-accumulate sequencer
// depends on smm_pkg, smm_ram and smm_out_if

module smm_back #(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [smm_pkg::SIZE_W-1:0]    n_eff,
	input  smm_pkg::qent_t                head,
	input  smm_pkg::qstat_t               qstat,
	output logic                          pop,
	smm_out_if.source                     results
);

	localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_RUN  = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	logic [IW-1:0] r_q, c_q, k_q;
	logic last_k, last_c, last_r;
	logic en;
	logic we_a, we_b;
	logic [AW-1:0] raddr_a, raddr_b;
	logic [smm_pkg::ELEM_W-1:0] rdata_a, rdata_b;

	// read stage tags
	logic v_s1, first_s1, lastk_s1, lastel_s1;
	logic [IW-1:0] row_s1, col_s1;
	// multiply stage
	logic v_s2, first_s2, lastk_s2, lastel_s2;
	logic [IW-1:0] row_s2, col_s2;
	logic signed [smm_pkg::PROD_W-1:0] prod_s2;
	// accumulator and output
	logic signed [smm_pkg::SUM_W-1:0] acc_q;
	logic signed [smm_pkg::SUM_W-1:0] sum;
	logic out_valid_q;

	// whole back pipeline moves only when the output register can take a result
	assign en = !out_valid_q || results.ready;

	assign last_k = (4'(k_q) + 4'd1 == n_eff);
	assign last_c = (4'(c_q) + 4'd1 == n_eff);
	assign last_r = (4'(r_q) + 4'd1 == n_eff);

	// take the next operation once the sequencer is free
	assign pop  = en && (state_q == SEQ_IDLE) && !qstat.empty;
	assign we_a = pop && (head.op == smm_pkg::OP_LOAD_A);
	assign we_b = pop && (head.op == smm_pkg::OP_LOAD_B);

	// operand addresses A[r][k] and B[k][c]
	assign raddr_a = AW'(32'(r_q) * MAX_DIM + 32'(k_q));
	assign raddr_b = AW'(32'(k_q) * MAX_DIM + 32'(c_q));

	smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(DEPTH)) u_left_store (
		.clk   (clk),
		.we    (we_a),
		.waddr (head.addr[AW-1:0]),
		.wdata (head.value),
		.re    (en),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(DEPTH)) u_right_store (
		.clk   (clk),
		.we    (we_b),
		.waddr (head.addr[AW-1:0]),
		.wdata (head.value),
		.re    (en),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// sequencer over row, column and dot-product step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else if (en) begin
			case (state_q)
				SEQ_IDLE: begin
					if (pop && head.op == smm_pkg::OP_COMPUTE) begin
						state_q <= SEQ_RUN;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
					end
				end
				SEQ_RUN: begin
					if (!last_k) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (!last_c) begin
							c_q <= c_q + 1'b1;
						end else begin
							c_q <= '0;
							if (!last_r) begin
								r_q <= r_q + 1'b1;
							end else begin
								r_q     <= '0;
								state_q <= SEQ_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= (state_q == SEQ_RUN);
			v_s2 <= v_s1;
		end
	end

	// pipeline tags and product
	always_ff @(posedge clk) begin
		if (en) begin
			first_s1  <= (k_q == '0);
			lastk_s1  <= last_k;
			lastel_s1 <= last_r && last_c;
			row_s1    <= r_q;
			col_s1    <= c_q;
			first_s2  <= first_s1;
			lastk_s2  <= lastk_s1;
			lastel_s2 <= lastel_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			prod_s2   <= $signed(rdata_a) * $signed(rdata_b);
		end
	end

	// running sum, restarted on the first product of each element
	assign sum = (first_s2 ? '0 : acc_q) + smm_pkg::SUM_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			acc_q <= sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s2 && lastk_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2 && lastk_s2) begin
			results.out_row       <= 3'(row_s2);
			results.out_col       <= 3'(col_s2);
			results.product_value <= sum;
			results.last_of_run   <= lastel_s2;
		end
	end

	assign results.valid = out_valid_q;

endmodule

// File: hw/rtl/square_matrix_multiply_top.sv
// square_matrix_multiply_top: top level of the square matrix multiply block
// depends on smm_pkg, smm_in_if, smm_out_if, smm_front, smm_queue and smm_back
//
// Computes C = A x B for square matrices of size n (matrix_size, clamped to
// MAX_DIM) with signed Q8.8 elements and exact signed Q24.16 sums in 40 bits.
// Load items write one element of A or B; loads outside n, kind 3 and a
// compute with n of zero are dropped at the input. Accepted items pass a
// four-entry queue, so the input keeps taking items during a compute while
// the queue has room. A load is written into its store when the back pops
// it. A compute item runs one multiply-accumulate per cycle, unless the
// output stalls, on the single read port of each store, and emits the n*n
// elements of C in row-major order with last_of_run on the final one. The
// whole back pipeline holds while a result waits on the output. Elements of
// A or B that were never written read as arbitrary values.

module square_matrix_multiply_top #(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [smm_pkg::SIZE_W-1:0] cfg_wdata,
	smm_in_if.sink                     items,
	smm_out_if.source                  results
);

	logic [smm_pkg::SIZE_W-1:0] matrix_size_q;
	logic [smm_pkg::SIZE_W-1:0] n_eff;
	logic                       push;
	logic                       pop;
	smm_pkg::qent_t             push_entry;
	smm_pkg::qent_t             head;
	smm_pkg::qstat_t            qstat;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= smm_pkg::SIZE_W'(8);
		end else if (cfg_we) begin
			matrix_size_q <= cfg_wdata;
		end
	end

	// sizes above the maximum act as the maximum
	assign n_eff = (matrix_size_q > smm_pkg::SIZE_W'(MAX_DIM)) ?
		smm_pkg::SIZE_W'(MAX_DIM) : matrix_size_q;

	smm_front #(.MAX_DIM(MAX_DIM)) u_front (
		.items (items),
		.n_eff (n_eff),
		.qstat (qstat),
		.push  (push),
		.entry (push_entry)
	);

	smm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	smm_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.n_eff   (n_eff),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

// File: hw/rtl/smm_checker.sv
// smm_checker: port-level assertions for the square matrix multiply block
// bound to square_matrix_multiply_top; depends on smm_pkg

module smm_checker #(
	parameter int unsigned MAX_DIM = 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic [smm_pkg::SIZE_W-1:0] cfg_wdata,
	input logic                       results_valid,
	input logic                       results_ready,
	input logic [2:0]                 out_row,
	input logic [2:0]                 out_col,
	input logic signed [39:0]         product_value,
	input logic                       last_of_run
);

	logic [smm_pkg::SIZE_W-1:0] size_q;
	logic [smm_pkg::SIZE_W-1:0] n_ck;

	// shadow of the size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= smm_pkg::SIZE_W'(8);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	assign n_ck = (size_q > smm_pkg::SIZE_W'(MAX_DIM)) ? smm_pkg::SIZE_W'(MAX_DIM) : size_q;

	// a stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_ready |=> results_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_ready |=> $stable(out_row) && $stable(out_col)
			&& $stable(product_value) && $stable(last_of_run))
		else $error("result payload changed while stalled");

	// emitted coordinates lie inside the active matrix
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid |-> ({1'b0, out_row} < n_ck) && ({1'b0, out_col} < n_ck))
		else $error("result coordinate outside matrix size");

	// the last element of a run is the bottom-right corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && last_of_run |->
			({1'b0, out_row} + 4'd1 == n_ck) && ({1'b0, out_col} + 4'd1 == n_ck))
		else $error("last_of_run not on the final element");

	// no result right out of reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !results_valid)
		else $error("result offered right after reset");

endmodule

bind square_matrix_multiply_top smm_checker #(.MAX_DIM(MAX_DIM)) u_smm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_wdata     (cfg_wdata),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.out_row       (results.out_row),
	.out_col       (results.out_col),
	.product_value (results.product_value),
	.last_of_run   (results.last_of_run)
);
